// ----- design/clf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the cascaded line-follow controller.
package clf_pkg;

	localparam int PWM_LOW_DEF      = -8000;
	localparam int PWM_HIGH_DEF     = 8000;
	localparam int OUTER_DIVIDE_DEF = 2;

	localparam int GAIN_W = 32;
	localparam int SIG_W  = 16;
	localparam int NUM_W  = 56;  // filter numerator width
	localparam int DIV_W  = 36;  // divider dividend width after the Q20 shift

	localparam logic [2:0] REG_LINE_KP  = 3'd0;
	localparam logic [2:0] REG_LINE_KD  = 3'd1;
	localparam logic [2:0] REG_YAW_KP   = 3'd2;
	localparam logic [2:0] REG_YAW_KD   = 3'd3;
	localparam logic [2:0] REG_LEFT_KP  = 3'd4;
	localparam logic [2:0] REG_LEFT_KI  = 3'd5;
	localparam logic [2:0] REG_RIGHT_KP = 3'd6;
	localparam logic [2:0] REG_RIGHT_KI = 3'd7;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LD_MUL,
		S_LD_DIV,
		S_LD_WAIT,
		S_LP_MUL,
		S_YF_DIV,
		S_YF_WAIT,
		S_YD_MUL,
		S_YD_DIV,
		S_YD_WAIT,
		S_YP_MUL,
		S_YP_SUM,
		S_W_ERR,
		S_W_KP,
		S_W_KI,
		S_W_ACC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic shift20;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// divide by 2^20, truncating toward zero
	function automatic logic signed [45:0] trunc_q20(input logic signed [65:0] x);
		logic signed [65:0] t;
		t = x + (x[65] ? 66'sd1048575 : 66'sd0);
		return t[65:20];
	endfunction

endpackage

// ----- design/clf_mul.sv -----
// Shared signed 32x32 multiplier with a registered product.
module clf_mul (
	input  logic                     clk,
	input  logic signed [31:0]       a,
	input  logic signed [31:0]       b,
	output logic signed [63:0]       p_q
);
	import clf_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// ----- design/clf_div.sv -----
// Iterative signed divide by ten on one shared shift-add unit, with an optional truncating divide by 2^20 first.
module clf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  clf_pkg::div_req_t               req,
	input  logic signed [clf_pkg::NUM_W-1:0] num,
	output logic                            done_q,
	output logic signed [clf_pkg::DIV_W:0]  quot
);
	import clf_pkg::*;

	localparam int R_W = DIV_W + 4;
	localparam logic [2:0] LAST_STEP = 3'd6;

	logic [NUM_W-1:0] mag;
	logic [NUM_W-1:0] mag_sh;
	logic [DIV_W-1:0] n_q;
	logic [DIV_W-1:0] q_q;
	logic [R_W-1:0]   q_x10;
	logic [R_W-1:0]   rem;
	logic [DIV_W-1:0] add_a;
	logic [DIV_W-1:0] add_b;
	logic             neg_q;
	logic             busy_q;
	logic [2:0]       step_q;

	assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign mag_sh = req.shift20 ? (mag >> 20) : mag;
	assign q_x10  = (R_W'(q_q) << 3) + (R_W'(q_q) << 1);
	assign rem    = R_W'(n_q) - q_x10;

	// build n * 0.8 by a shift-add series, scale to n / 10, then bump a low estimate by one
	always_comb begin
		add_a = q_q;
		add_b = '0;
		case (step_q)
			3'd0: begin
				add_a = n_q >> 1;
				add_b = n_q >> 2;
			end
			3'd1: add_b = q_q >> 4;
			3'd2: add_b = q_q >> 8;
			3'd3: add_b = q_q >> 16;
			3'd4: add_b = q_q >> 32;
			3'd5: add_a = q_q >> 3;
			default: add_b = DIV_W'(rem > R_W'(9));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= num[NUM_W-1];
			n_q   <= mag_sh[DIV_W-1:0];
		end else if (busy_q) begin
			q_q <= add_a + add_b;
		end
	end

	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

// ----- design/cascaded_line_follow_pid_top.sv -----
// Throughput: one beat at a time; the next beat is taken the cycle after the result beat leaves.
// Outer-loop ticks add three passes through the shift-add divide-by-ten unit;
// all products go through one shared 32x32 multiplier.
// Reset clears all loop state and the tick phase and loads the default gains.
// Top level: configuration registers, sequencer and datapath of the cascaded controller.
module cascaded_line_follow_pid_top #(
	parameter int PWM_LOW      = clf_pkg::PWM_LOW_DEF,
	parameter int PWM_HIGH     = clf_pkg::PWM_HIGH_DEF,
	parameter int OUTER_DIVIDE = clf_pkg::OUTER_DIVIDE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [15:0]     line_weight,
	input  logic signed [15:0]     yaw_rate,
	input  logic signed [15:0]     left_count,
	input  logic signed [15:0]     right_count,
	input  logic signed [15:0]     base_speed,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     left_drive,
	output logic signed [15:0]     right_drive
);
	import clf_pkg::*;

	localparam int PH_W = (OUTER_DIVIDE > 1) ? $clog2(OUTER_DIVIDE) : 1;
	localparam logic signed [47:0] PWM_LO48 = 48'(PWM_LOW);
	localparam logic signed [47:0] PWM_HI48 = 48'(PWM_HIGH);

	state_t state_q, state_d;

	logic signed [31:0] line_kp_q, line_kd_q, yaw_kp_q, yaw_kd_q;
	logic signed [31:0] left_kp_q, left_ki_q, right_kp_q, right_ki_q;

	logic [PH_W-1:0]    phase_q;
	logic signed [15:0] lw_q, yr_q, lc_q, rc_q, base_q;
	logic signed [16:0] lep_q, yf_q, yold_q;
	logic signed [31:0] ldf_q, ydf_q, target_q, yerr_q, steer_q;
	logic signed [31:0] lerr_q, rerr_q, werr_q, wd_q;
	logic signed [15:0] lacc_q, racc_q;
	logic signed [63:0] p1_q;
	logic               side_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] p_q;
	div_req_t           dreq;
	logic signed [NUM_W-1:0] dnum;
	logic               ddone;
	logic signed [DIV_W:0] dquot;

	logic               accept;
	logic signed [16:0] e_line;
	logic signed [17:0] d_line, d_yaw;
	logic signed [31:0] w_tgt, w_err, w_diff, w_dclamp, w_ep;
	logic signed [15:0] w_cnt, w_acc;
	logic signed [64:0] w_sum;
	logic signed [45:0] w_inc;
	logic signed [47:0] w_nacc;
	logic signed [15:0] w_accn;

	function automatic logic signed [NUM_W-1:0] fnum(input logic signed [63:0] p,
			input logic signed [31:0] old);
		logic signed [NUM_W-1:0] p56;
		logic signed [NUM_W-1:0] o56;
		p56 = p[NUM_W-1:0];
		o56 = NUM_W'(old);
		return (p56 <<< 3) - p56 + (o56 <<< 21) + (o56 <<< 20);
	endfunction

	clf_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	clf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.num    (dnum),
		.done_q (ddone),
		.quot   (dquot)
	);

	assign accept = in_valid && !in_stall;
	assign e_line = -{lw_q[15], lw_q};
	assign d_line = {e_line[16], e_line} - {lep_q[16], lep_q};
	assign d_yaw  = {yold_q[16], yold_q} - {yf_q[16], yf_q};

	// wheel side datapath, shared by both wheels
	assign w_cnt  = side_q ? rc_q : lc_q;
	assign w_ep   = side_q ? rerr_q : lerr_q;
	assign w_acc  = side_q ? racc_q : lacc_q;
	assign w_tgt  = side_q ? sat32(48'(base_q) + 48'(steer_q)) : sat32(48'(base_q) - 48'(steer_q));
	assign w_err  = sat32(48'(w_tgt) - 48'(w_cnt));
	assign w_diff = sat32(48'(w_err) - 48'(w_ep));
	assign w_dclamp = (w_diff == 32'sh80000000) ? 32'sh80000001 : w_diff;
	assign w_sum  = 65'(p1_q) + 65'(p_q);
	assign w_inc  = trunc_q20(66'(w_sum));
	assign w_nacc = 48'(w_acc) + 48'(w_inc);
	assign w_accn = (w_nacc > PWM_HI48) ? PWM_HI48[15:0] :
	                (w_nacc < PWM_LO48) ? PWM_LO48[15:0] : w_nacc[15:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = (phase_q == '0) ? S_LD_MUL : S_W_ERR;
			S_LD_MUL:  state_d = S_LD_DIV;
			S_LD_DIV:  state_d = S_LD_WAIT;
			S_LD_WAIT: if (ddone) state_d = S_LP_MUL;
			S_LP_MUL:  state_d = S_YF_DIV;
			S_YF_DIV:  state_d = S_YF_WAIT;
			S_YF_WAIT: if (ddone) state_d = S_YD_MUL;
			S_YD_MUL:  state_d = S_YD_DIV;
			S_YD_DIV:  state_d = S_YD_WAIT;
			S_YD_WAIT: if (ddone) state_d = S_YP_MUL;
			S_YP_MUL:  state_d = S_YP_SUM;
			S_YP_SUM:  state_d = S_W_ERR;
			S_W_ERR:   state_d = S_W_KP;
			S_W_KP:    state_d = S_W_KI;
			S_W_KI:    state_d = S_W_ACC;
			S_W_ACC:   state_d = side_q ? S_OUT : S_W_ERR;
			S_OUT:     if (!out_stall) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != S_IDLE);
		out_valid    = (state_q == S_OUT);
		mul_a        = '0;
		mul_b        = '0;
		dreq.start   = 1'b0;
		dreq.shift20 = 1'b1;
		dnum         = '0;
		case (state_q)
			S_LD_MUL: begin
				mul_a = line_kd_q;
				mul_b = 32'(d_line);
			end
			S_LP_MUL: begin
				mul_a = line_kp_q;
				mul_b = 32'(e_line);
			end
			S_YD_MUL: begin
				mul_a = yaw_kd_q;
				mul_b = 32'(d_yaw);
			end
			S_YP_MUL: begin
				mul_a = yaw_kp_q;
				mul_b = yerr_q;
			end
			S_W_KP: begin
				mul_a = side_q ? right_kp_q : left_kp_q;
				mul_b = wd_q;
			end
			S_W_KI: begin
				mul_a = side_q ? right_ki_q : left_ki_q;
				mul_b = werr_q;
			end
			S_LD_DIV: begin
				dreq.start = 1'b1;
				dnum       = fnum(p_q, ldf_q);
			end
			S_YF_DIV: begin
				dreq.start   = 1'b1;
				dreq.shift20 = 1'b0;
				dnum = (NUM_W'(yr_q) <<< 3) - NUM_W'(yr_q)
				     + (NUM_W'(yf_q) <<< 1) + NUM_W'(yf_q);
			end
			S_YD_DIV: begin
				dreq.start = 1'b1;
				dnum       = fnum(p_q, ydf_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			side_q  <= 1'b0;
			line_kp_q  <= 32'sd1069547520;
			line_kd_q  <= 32'sd0;
			yaw_kp_q   <= 32'sd26424;
			yaw_kd_q   <= 32'sd4719;
			left_kp_q  <= 32'sd337641472;
			left_ki_q  <= 32'sd16986931;
			right_kp_q <= 32'sd335544320;
			right_ki_q <= 32'sd18140365;
			lep_q  <= '0;
			ldf_q  <= '0;
			yf_q   <= '0;
			ydf_q  <= '0;
			steer_q <= '0;
			lerr_q <= '0;
			rerr_q <= '0;
			lacc_q <= '0;
			racc_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LINE_KP:  line_kp_q  <= cfg_data;
					REG_LINE_KD:  line_kd_q  <= cfg_data;
					REG_YAW_KP:   yaw_kp_q   <= cfg_data;
					REG_YAW_KD:   yaw_kd_q   <= cfg_data;
					REG_LEFT_KP:  left_kp_q  <= cfg_data;
					REG_LEFT_KI:  left_ki_q  <= cfg_data;
					REG_RIGHT_KP: right_kp_q <= cfg_data;
					REG_RIGHT_KI: right_ki_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				side_q  <= 1'b0;
				phase_q <= (phase_q == PH_W'(OUTER_DIVIDE - 1)) ? '0 : phase_q + 1'b1;
			end
			case (state_q)
				S_LD_WAIT: if (ddone) begin
					ldf_q <= sat32(48'(dquot));
					lep_q <= e_line;
				end
				S_YF_WAIT: if (ddone) begin
					yold_q <= yf_q;
					yf_q   <= dquot[16:0];
					yerr_q <= sat32(48'(target_q) - 48'(dquot));
				end
				S_YD_WAIT: if (ddone) ydf_q <= sat32(48'(dquot));
				S_YP_SUM:  steer_q <= sat32(48'(trunc_q20(66'(p_q))) + 48'(ydf_q));
				S_W_ACC: begin
					side_q <= 1'b1;
					if (side_q) begin
						racc_q <= w_accn;
						rerr_q <= werr_q;
					end else begin
						lacc_q <= w_accn;
						lerr_q <= werr_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lw_q   <= line_weight;
			yr_q   <= yaw_rate;
			lc_q   <= left_count;
			rc_q   <= right_count;
			base_q <= base_speed;
		end
		if (state_q == S_YF_DIV) begin
			target_q <= sat32(48'(trunc_q20(66'(p_q))) + 48'(ldf_q));
		end
		if (state_q == S_W_ERR) begin
			werr_q <= w_err;
			wd_q   <= w_dclamp;
		end
		if (state_q == S_W_KI) begin
			p1_q <= p_q;
		end
	end

	assign left_drive  = lacc_q;
	assign right_drive = racc_q;

endmodule
